// ----- hdl/pidl_pkg.sv -----
// Shared types, codes and field layout for the positional insert/delete list.
package pidl_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Input word layout.
    localparam int OPC_W = 2;
    localparam int POS_W = 16;
    localparam int DIN_W = 32;
    localparam int S_TDATA_W = 56;

    // Result word layout.
    localparam int STS_W = 2;
    localparam int PLC_W = 5;
    localparam int RD_W = 32;
    localparam int CNT_W = 5;
    localparam int M_TDATA_W = 48;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef enum logic [STS_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_RANGE
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_stall;
    } ctrl_sts_t;

endpackage

// ----- hdl/positional_insert_delete_list.sv -----
// Top level of the positional insert/delete list.
//
// Input channel (s_): one word per operation: insert, delete, read or clear, with a
// position and, for insert, the entry value. Result channel (m_): exactly one word
// per operation with status, insert slot, read value, entry count and full flag.
// Configuration: cfg_wr_en with cfg_wr_data writes the capacity; write it only while
// no operation is outstanding.
//
// Timing: a word is captured into the input registers when accepted and is executed
// in the S_EXEC state once the result slot is free; the execute step registers its
// result word onto m_tdata. A new word is taken only after the previous one has
// executed, set by the two-state controller (capture, then execute). All entry cells
// shift in parallel, so list length does not change the timing.
//
// Reset empties the list (count zero), sets the capacity to 16 and drops m_tvalid.
// Entry values are not cleared. When the receiver stalls, the result is held and one
// further word may be accepted; its execution waits until the result slot is taken.
module positional_insert_delete_list #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF,
    parameter int WIDTH = pidl_pkg::WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // opcode[1:0], position[17:2], entry_data[49:18], zero fill above
    input  logic [pidl_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], placed_at[6:2], read_data[38:7], entry_count[43:39], is_full[44]
    output logic [pidl_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [pidl_pkg::CAP_W-1:0]       cfg_wr_data
);
    import pidl_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    pidl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    pidl_datapath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ----- hdl/pidl_ctrl.sv -----
// Controller state machine: captures a word, then executes it once the result slot frees.
module pidl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output pidl_pkg::ctrl_cmd_t cmd,
    input  pidl_pkg::ctrl_sts_t sts
);
    import pidl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!sts.out_stall) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            S_EXEC: begin
                cmd.exec = !sts.out_stall;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/pidl_datapath.sv -----
// Datapath: input capture, the shifting row of entry cells, count, capacity and result register.
module pidl_datapath #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF,
    parameter int WIDTH = pidl_pkg::WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pidl_pkg::ctrl_cmd_t              cmd,
    output pidl_pkg::ctrl_sts_t              sts,
    input  logic [pidl_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             cfg_wr_en,
    input  logic [pidl_pkg::CAP_W-1:0]       cfg_wr_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pidl_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pidl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;

    op_t                    op_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [DIN_W-1:0]       din_reg;
    logic [WIDTH-1:0]       cells_reg [DEPTH];
    logic [WIDTH-1:0]       cells_next [DEPTH];
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [CAP_W-1:0]       cap_reg;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg;
    logic [M_TDATA_W-1:0]   m_data_next;

    logic                   pos_lt_count;
    logic                   pos_gt_count;
    logic [CW-1:0]          at_idx;
    logic                   full_cur;
    logic                   full_new;
    logic                   ins_ok;
    logic                   del_ok;
    logic                   rd_ok;
    logic [WIDTH-1:0]       rd_word;
    logic [WIDTH-1:0]       store_word;
    status_t                status;
    logic [PLC_W-1:0]       placed;
    logic [RD_W-1:0]        rdata;

    // Full once the count reaches the configured capacity, clipped to the cell count.
    function automatic logic full_of(input logic [CW-1:0] c, input logic [CAP_W-1:0] cap);
        logic [XW-1:0] cap_x;
        logic [XW-1:0] eff;
        cap_x = XW'(cap);
        eff   = (cap_x < XW'(DEPTH)) ? cap_x : XW'(DEPTH);
        return XW'(c) >= eff;
    endfunction

    assign pos_lt_count = pos_reg < POS_W'(count_reg);
    assign pos_gt_count = pos_reg > POS_W'(count_reg);
    assign at_idx       = pos_gt_count ? count_reg : pos_reg[CW-1:0];
    assign full_cur     = full_of(count_reg, cap_reg);
    assign ins_ok       = (op_reg == OP_INSERT) && !full_cur;
    assign del_ok       = (op_reg == OP_DELETE) && pos_lt_count;
    assign rd_ok        = (op_reg == OP_READ) && pos_lt_count;
    assign store_word   = WIDTH'(din_reg);
    assign rd_word      = cells_reg[pos_reg[IW-1:0]];

    // Each cell reads only itself, its two neighbors and the new entry, so the whole row shifts in parallel.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        always_comb begin
            cells_next[i] = cells_reg[i];
            if (cmd.exec && ins_ok) begin
                if (CW'(i) == at_idx) begin
                    cells_next[i] = store_word;
                end else if (CW'(i) > at_idx) begin
                    if (i > 0) begin
                        cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end else if (cmd.exec && del_ok) begin
                if ((POS_W'(i) >= pos_reg) && (i < DEPTH - 1)) begin
                    cells_next[i] = cells_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.exec) begin
            case (op_reg)
                OP_INSERT: begin
                    if (ins_ok) begin
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_DELETE: begin
                    if (del_ok) begin
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_comb begin
        status = ST_OK;
        case (op_reg)
            OP_INSERT: begin
                if (!ins_ok) begin
                    status = ST_FULL;
                end
            end
            OP_DELETE: begin
                if (!del_ok) begin
                    status = ST_RANGE;
                end
            end
            OP_READ: begin
                if (!rd_ok) begin
                    status = ST_RANGE;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign full_new    = full_of(count_next, cap_reg);
    assign placed      = ins_ok ? PLC_W'(at_idx) : '0;
    assign rdata       = rd_ok ? RD_W'(rd_word) : '0;
    assign m_data_next = {3'b000, full_new, CNT_W'(count_next), rdata, placed, status};

    // The result slot frees as it is taken, so a new result may land in the same cycle.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign sts.out_stall = m_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= op_t'(s_tdata[OPC_W-1:0]);
            pos_reg <= s_tdata[OPC_W +: POS_W];
            din_reg <= s_tdata[OPC_W+POS_W +: DIN_W];
        end
        if (cmd.exec) begin
            m_data_reg <= m_data_next;
        end
        cells_reg <= cells_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- hdl/pidl_checker.sv -----
// Port-level checker for the list, bound to the top level.
module pidl_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pidl_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pidl_pkg::*;

    logic [STS_W-1:0] sts_f;
    logic [PLC_W-1:0] plc_f;
    logic [RD_W-1:0]  rd_f;
    logic             full_f;

    assign sts_f  = m_tdata[STS_W-1:0];
    assign plc_f  = m_tdata[STS_W +: PLC_W];
    assign rd_f   = m_tdata[STS_W+PLC_W +: RD_W];
    assign full_f = m_tdata[STS_W+PLC_W+RD_W+CNT_W];

    // A held result word must not change until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // A failed insert can only happen on a full list, which stays full.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && sts_f == ST_FULL |-> full_f)
        else $error("insert refused on a list that is not full");

    // Insert slot and read value are only reported on success.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && sts_f != ST_OK |-> plc_f == '0 && rd_f == '0)
        else $error("failed operation reported a slot or value");

    // After taking a word the block is in its execute state in the next cycle, with input ready low.
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted word");

    // Nothing comes out in the cycle after reset.
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind positional_insert_delete_list pidl_checker u_pidl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
